@@ hdl/periodic_subscription_timer_table_unit_assert.svh @@
// Assertion macros for the periodic subscription timer table.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PERIODIC_SUBSCRIPTION_TIMER_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_SUBSCRIPTION_TIMER_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// expr holds at every clock edge out of reset
`define PSTT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("pstt: invariant violated");
// cons holds in the same cycle as ante
`define PSTT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pstt: implication violated");
// cons holds in the cycle after ante
`define PSTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pstt: next-cycle check violated");
`else
`define PSTT_ASSERT_ALWAYS(label, clk, rst, expr)
`define PSTT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PSTT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/pstt_pkg.sv @@
// Shared types and constants for the periodic subscription timer table.
// No dependencies; used by every module of the block.
package pstt_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int ID_W        = 8;
   localparam int IVL_W       = 16;
   localparam int OP_W        = 3;
   localparam int MODE_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_SUBSCRIBE   = 3'd0;
   localparam logic [OP_W-1:0] OP_UNSUBSCRIBE = 3'd1;
   localparam logic [OP_W-1:0] OP_CANCEL_ALL  = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK        = 3'd3;
   localparam logic [OP_W-1:0] OP_POP         = 3'd4;

   // rate modes; anything else counts as slow
   localparam logic [MODE_W-1:0] MODE_MEDIUM = 8'd2;
   localparam logic [MODE_W-1:0] MODE_FAST   = 8'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEDIUM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST   = 2'd2;

   localparam logic [IVL_W-1:0] SLOW_RESET   = 16'd1000;
   localparam logic [IVL_W-1:0] MEDIUM_RESET = 16'd300;
   localparam logic [IVL_W-1:0] FAST_RESET   = 16'd100;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE_DUE = 2'd2;

   // one slot as held in the slot memory
   typedef struct packed {
      logic [ID_W-1:0]  ident;
      logic [IVL_W-1:0] reload;
      logic [IVL_W-1:0] countdown;
   } entry_type;

   // verdict of the slot unit on the slot under the walk
   typedef struct packed {
      logic             hit;
      logic             free;
      logic             wr_en;
      logic             set_due;
      logic [IVL_W-1:0] countdown;
   } alu_out_type;

endpackage

@@ hdl/pstt_slot_mem.sv @@
// Slot memory: one write port, one read port with registered read data.
// Depends on pstt_pkg for the entry type.
module pstt_slot_mem #(
   parameter int DEPTH = pstt_pkg::SLOTS_DEFAULT,
   parameter int AW    = 3
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pstt_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output pstt_pkg::entry_type rd_data
);

   pstt_pkg::entry_type slot_mem [DEPTH];
   pstt_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   // read port, data registered in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pstt_slot_alu.sv @@
// Shared slot unit: identifier compare, due test and countdown step for one slot.
// Depends on pstt_pkg for op codes and the entry and verdict types.
module pstt_slot_alu (
   input  logic [pstt_pkg::OP_W-1:0] op,
   input  logic [pstt_pkg::ID_W-1:0] sub_id,
   input  logic                      slot_valid,
   input  logic                      slot_due,
   input  pstt_pkg::entry_type       entry,
   output pstt_pkg::alu_out_type     result
);

   logic [pstt_pkg::IVL_W-1:0] dec;
   logic                       fire;
   logic                       is_tick;

   // countdown step: saturate at zero, reload when it lands on zero
   assign dec     = (entry.countdown != '0) ? entry.countdown - 1'b1 : '0;
   assign fire    = (dec == '0);
   assign is_tick = (op == pstt_pkg::OP_TICK);

   always_comb begin
      result.free      = !slot_valid;
      result.wr_en     = is_tick && slot_valid;
      result.set_due   = is_tick && slot_valid && fire;
      result.countdown = fire ? entry.reload : dec;
      case (op) inside
         pstt_pkg::OP_SUBSCRIBE, pstt_pkg::OP_UNSUBSCRIBE:
            result.hit = slot_valid && (entry.ident == sub_id);
         pstt_pkg::OP_POP:
            result.hit = slot_valid && slot_due;
         default:
            result.hit = 1'b0;
      endcase
   end

endmodule

@@ hdl/periodic_subscription_timer_table_unit.sv @@
// Top level of the periodic subscription timer table: sequencer, slot flags,
// interval registers. Depends on pstt_pkg, pstt_slot_mem, pstt_slot_alu.
//
// Usage:
//  - Commands: present req_op, req_sub_id, req_rate_mode with start; the beat
//    is taken at a clock edge where start is high and busy is low.
//  - Each command gives one result beat: rsp_valid is high for one cycle with
//    rsp_status and rsp_due_id. The receiver cannot stall; the beat must be
//    taken in that cycle.
//  - Subscribe, unsubscribe, tick and pop walk the slot memory one slot per
//    cycle through the shared slot unit, then commit; cancel-all and unknown
//    ops go straight to commit. rsp_valid is registered from the commit state
//    and busy falls with it, so the next command is taken at the edge that
//    takes the result; no new command is taken while one is in flight.
//  - csr_write_enable/csr_index/csr_write_data write the slow, medium or fast
//    interval (index 0, 1, 2), one per write; write only while busy is low.
//  - Reset (synchronous, active high) frees every slot, clears all due flags
//    and loads the interval defaults 1000, 300 and 100. Slot valid bits are
//    flip-flops, so no clearing pass is needed.
`include "periodic_subscription_timer_table_unit_assert.svh"

module periodic_subscription_timer_table_unit #(
   parameter int SLOTS = pstt_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [pstt_pkg::OP_W-1:0]        req_op,
   input  logic [pstt_pkg::ID_W-1:0]        req_sub_id,
   input  logic [pstt_pkg::MODE_W-1:0]      req_rate_mode,
   output logic                             rsp_valid,
   output logic [pstt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [pstt_pkg::ID_W-1:0]        rsp_due_id,
   input  logic                             csr_write_enable,
   input  logic [pstt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pstt_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [pstt_pkg::OP_W-1:0]           op_ff, op_in;
   logic [pstt_pkg::ID_W-1:0]           id_ff, id_in;
   logic [pstt_pkg::IVL_W-1:0]          iv_ff, iv_in;
   logic [IDX_W-1:0]                    idx_ff, idx_in;
   logic                                match_ff, match_in;
   logic [IDX_W-1:0]                    match_idx_ff, match_idx_in;
   logic                                free_ff, free_in;
   logic [IDX_W-1:0]                    free_idx_ff, free_idx_in;
   logic [pstt_pkg::ID_W-1:0]           pop_ident_ff, pop_ident_in;
   logic [SLOTS-1:0]                    valid_ff, valid_in;
   logic [SLOTS-1:0]                    due_ff, due_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [pstt_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [pstt_pkg::ID_W-1:0]           rsp_due_id_ff, rsp_due_id_in;
   logic [pstt_pkg::IVL_W-1:0]          slow_ff, medium_ff, fast_ff;
   logic [pstt_pkg::IVL_W-1:0]          req_interval;

   logic                                wr_en;
   logic [IDX_W-1:0]                    wr_addr;
   pstt_pkg::entry_type                 wr_data;
   logic [IDX_W-1:0]                    rd_addr;
   pstt_pkg::entry_type                 rd_data;
   pstt_pkg::alu_out_type               alu_out;

   // slot storage
   pstt_slot_mem #(
      .DEPTH (SLOTS),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared slot unit, fed the slot under the walk
   pstt_slot_alu u_alu (
      .op         (op_ff),
      .sub_id     (id_ff),
      .slot_valid (valid_ff[idx_ff]),
      .slot_due   (due_ff[idx_ff]),
      .entry      (rd_data),
      .result     (alu_out)
   );

   // interval registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slow_ff   <= pstt_pkg::SLOW_RESET;
         medium_ff <= pstt_pkg::MEDIUM_RESET;
         fast_ff   <= pstt_pkg::FAST_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pstt_pkg::CSR_SLOW:   slow_ff   <= csr_write_data;
            pstt_pkg::CSR_MEDIUM: medium_ff <= csr_write_data;
            pstt_pkg::CSR_FAST:   fast_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // interval for the incoming command
   always_comb begin
      case (req_rate_mode)
         pstt_pkg::MODE_MEDIUM: req_interval = medium_ff;
         pstt_pkg::MODE_FAST:   req_interval = fast_ff;
         default:               req_interval = slow_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      iv_in         = iv_ff;
      idx_in        = idx_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      pop_ident_in  = pop_ident_ff;
      valid_in      = valid_ff;
      due_in        = due_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = pstt_pkg::STATUS_OK;
      rsp_due_id_in = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data.ident     = rd_data.ident;
      wr_data.reload    = rd_data.reload;
      wr_data.countdown = alu_out.countdown;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               id_in    = req_sub_id;
               iv_in    = req_interval;
               idx_in   = '0;
               match_in = 1'b0;
               free_in  = 1'b0;
               case (req_op) inside
                  pstt_pkg::OP_SUBSCRIBE, pstt_pkg::OP_UNSUBSCRIBE,
                  pstt_pkg::OP_TICK, pstt_pkg::OP_POP:
                     state_in = ST_SCAN;
                  default:
                     state_in = ST_COMMIT;
               endcase
            end
         end

         ST_SCAN: begin
            // first matching or due slot
            if (alu_out.hit && !match_ff) begin
               match_in     = 1'b1;
               match_idx_in = idx_ff;
               pop_ident_in = rd_data.ident;
            end
            // first free slot
            if (alu_out.free && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            // tick write-back
            wr_en = alu_out.wr_en;
            if (alu_out.set_due) begin
               due_in[idx_ff] = 1'b1;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_COMMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               rd_addr  = idx_ff + 1'b1;
            end
         end

         ST_COMMIT: begin
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
            wr_data.ident     = id_ff;
            wr_data.reload    = iv_ff;
            wr_data.countdown = iv_ff;
            case (op_ff)
               pstt_pkg::OP_SUBSCRIBE: begin
                  if (id_ff == '0) begin
                     rsp_status_in = free_ff ? pstt_pkg::STATUS_OK : pstt_pkg::STATUS_FULL;
                  end else if (match_ff || free_ff) begin
                     wr_en            = 1'b1;
                     wr_addr          = match_ff ? match_idx_ff : free_idx_ff;
                     valid_in[wr_addr] = 1'b1;
                     due_in[wr_addr]   = 1'b0;
                  end else begin
                     rsp_status_in = pstt_pkg::STATUS_FULL;
                  end
               end
               pstt_pkg::OP_UNSUBSCRIBE: begin
                  if ((id_ff != '0) && match_ff) begin
                     valid_in[match_idx_ff] = 1'b0;
                     due_in[match_idx_ff]   = 1'b0;
                  end
               end
               pstt_pkg::OP_CANCEL_ALL: begin
                  valid_in = '0;
                  due_in   = '0;
               end
               pstt_pkg::OP_POP: begin
                  if (match_ff) begin
                     due_in[match_idx_ff] = 1'b0;
                     rsp_due_id_in        = pop_ident_ff;
                  end else begin
                     rsp_status_in = pstt_pkg::STATUS_NONE_DUE;
                  end
               end
               default: ;
            endcase
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         due_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         due_ff       <= due_in;
         rsp_valid_ff <= rsp_valid_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      iv_ff         <= iv_in;
      idx_ff        <= idx_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      pop_ident_ff  <= pop_ident_in;
      rsp_status_ff <= rsp_status_in;
      rsp_due_id_ff <= rsp_due_id_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_due_id = rsp_due_id_ff;

   // checks
   `PSTT_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `PSTT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `PSTT_ASSERT_NEXT(a_valid_commit_only, clock, reset, state_ff != ST_COMMIT, $stable(valid_ff))
   `PSTT_ASSERT_ALWAYS(a_due_needs_valid, clock, reset, (due_ff & ~valid_ff) == '0)
   `PSTT_ASSERT_IMPLY(a_none_due_zero_id, clock, reset, rsp_valid_ff && rsp_status_ff == pstt_pkg::STATUS_NONE_DUE, rsp_due_id_ff == '0)

endmodule
